[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the list design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define CLWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CLWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/clwc_pkg.sv]
// ----------------------------------------------------------------------------
// clwc_pkg
// Beat types, operation and status codes for the circular list block.
// ----------------------------------------------------------------------------
package clwc_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int DATA_W   = 32;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
    } op_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] cursor_value;
        logic signed [DATA_W-1:0] front_value;
    } res_item_t;

    // Write enables broadcast along the cell row
    typedef struct packed {
        logic link_a;
        logic link_b;
        logic value;
    } cell_we_t;

endpackage

[src/clwc_cell.sv]
// ----------------------------------------------------------------------------
// clwc_cell
// One node of the pool: holds a value and a next link, merges its own
// contents into the read chains when addressed.
// ----------------------------------------------------------------------------
module clwc_cell #(
    parameter int IDX_W    = 4,
    parameter int VAL_W    = 32,
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  clwc_pkg::cell_we_t we,
    input  logic [IDX_W-1:0]   link_a_addr,
    input  logic [IDX_W-1:0]   link_a_data,
    input  logic [IDX_W-1:0]   link_b_addr,
    input  logic [IDX_W-1:0]   link_b_data,
    input  logic [IDX_W-1:0]   val_wr_addr,
    input  logic [VAL_W-1:0]   val_wr_data,
    input  logic [IDX_W-1:0]   link_rd_addr,
    input  logic [IDX_W-1:0]   val_rd_addr,
    input  logic [IDX_W-1:0]   link_chain_in,
    output logic [IDX_W-1:0]   link_chain_out,
    input  logic [VAL_W-1:0]   val_chain_in,
    output logic [VAL_W-1:0]   val_chain_out
);
    import clwc_pkg::*;

    localparam logic [IDX_W-1:0] MY_INDEX   = IDX_W'(INDEX);
    localparam logic [IDX_W-1:0] RESET_LINK = (INDEX + 1 < CAPACITY) ? IDX_W'(INDEX + 1) : '0;

    logic [IDX_W-1:0] link_reg;
    logic [IDX_W-1:0] link_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb
    begin
        link_next = link_reg;
        if (we.link_b && (link_b_addr == MY_INDEX))
        begin
            link_next = link_b_data;
        end
        else if (we.link_a && (link_a_addr == MY_INDEX))
        begin
            link_next = link_a_data;
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (we.value && (val_wr_addr == MY_INDEX))
        begin
            value_next = val_wr_data;
        end
    end

    // Free list chain i -> i+1 at reset, last node wraps to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= RESET_LINK;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Merge into the read chains when addressed, pass through otherwise
    assign link_chain_out = link_chain_in | ((link_rd_addr == MY_INDEX) ? link_reg : '0);
    assign val_chain_out  = val_chain_in | ((val_rd_addr == MY_INDEX) ? value_reg : '0);

endmodule

[src/circular_list_with_cursor.sv]
// ----------------------------------------------------------------------------
// circular_list_with_cursor
// Circular linked list with a cursor, kept in a row of node cells.
// ----------------------------------------------------------------------------
// Usage:
//   op channel (op_valid/op_stall/op_item) carries one operation per beat:
//   add after cursor, remove after cursor, or advance the cursor.
//   res channel (res_valid/res_stall/res_item) returns one result beat per
//   operation: status, element count, removed value, cursor and front values.
//   An operation is taken in S_IDLE and finished in S_FINISH, which writes the
//   result register once it is free; no new op beat is taken until the
//   previous operation has finished. The two steps are the two dependent reads
//   through the cell row: a link read at accept, then a value read at finish.
//   While a result beat waits under res_stall, the next op is taken and held
//   in its finish step until the result register frees; op_stall stays high
//   meanwhile.
//   Reset empties the list: all nodes are chained as the free list, cursor
//   and free head at node 0, count zero, no result pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_list_with_cursor #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  clwc_pkg::op_item_t  op_item,
    output logic                res_valid,
    input  logic                res_stall,
    output clwc_pkg::res_item_t res_item
);
    import clwc_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

    typedef enum logic {
        S_IDLE,
        S_FINISH
    } state_t;

    // Read back a stored value sign-extended to the result width
    function automatic logic signed [DATA_W-1:0] widen(input logic [VALUE_WIDTH-1:0] v);
        logic signed [63:0] t;
        t = 64'(signed'(v));
        return t[DATA_W-1:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [VALUE_WIDTH-1:0]  item_val_reg, item_val_next;
    logic [IDX_W-1:0]        rd_link_reg, rd_link_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        nxt_reg, nxt_next;
    logic [IDX_W-1:0]        free_reg, free_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [VALUE_WIDTH-1:0]  cval_reg, cval_next;
    logic [VALUE_WIDTH-1:0]  fval_reg, fval_next;
    logic                    res_valid_reg, res_valid_next;
    res_item_t               res_item_reg, res_item_next;

    logic                    accept;
    logic                    load;
    logic signed [63:0]      in_ext;
    logic [IDX_W-1:0]        link_rd_addr;
    cell_we_t                we;
    logic [IDX_W-1:0]        link_a_addr, link_a_data;
    logic [IDX_W-1:0]        link_b_addr, link_b_data;
    logic [IDX_W-1:0]        val_wr_addr;
    logic [VALUE_WIDTH-1:0]  val_wr_data;
    logic [IDX_W-1:0]        link_chain [CAPACITY+1];
    logic [VALUE_WIDTH-1:0]  val_chain [CAPACITY+1];
    logic [VALUE_WIDTH-1:0]  val_rd;
    logic [STATUS_W-1:0]     status;
    logic signed [DATA_W-1:0] removed;

    assign accept   = op_valid && (state_reg == S_IDLE);
    assign load     = (state_reg == S_FINISH) && (!res_valid_reg || !res_stall);
    assign op_stall = (state_reg == S_FINISH);
    assign in_ext   = 64'(op_item.value);

    // Add pops the free head; remove and advance follow the front node
    assign link_rd_addr = (op_item.operation == OP_ADD) ? free_reg : nxt_reg;

    assign link_chain[0] = '0;
    assign val_chain[0]  = '0;
    assign val_rd        = val_chain[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        clwc_cell #(
            .IDX_W    (IDX_W),
            .VAL_W    (VALUE_WIDTH),
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .we             (we),
            .link_a_addr    (link_a_addr),
            .link_a_data    (link_a_data),
            .link_b_addr    (link_b_addr),
            .link_b_data    (link_b_data),
            .val_wr_addr    (val_wr_addr),
            .val_wr_data    (val_wr_data),
            .link_rd_addr   (link_rd_addr),
            .val_rd_addr    (rd_link_reg),
            .link_chain_in  (link_chain[i]),
            .link_chain_out (link_chain[i+1]),
            .val_chain_in   (val_chain[i]),
            .val_chain_out  (val_chain[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        item_val_next  = item_val_reg;
        rd_link_next   = rd_link_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        cval_next      = cval_reg;
        fval_next      = fval_reg;
        res_item_next  = res_item_reg;
        res_valid_next = res_valid_reg && res_stall;
        we             = '0;
        link_a_addr    = '0;
        link_a_data    = '0;
        link_b_addr    = '0;
        link_b_data    = '0;
        val_wr_addr    = '0;
        val_wr_data    = item_val_reg;
        status         = STATUS_OK;
        removed        = '0;

        if (accept)
        begin
            state_next    = S_FINISH;
            op_next       = op_item.operation;
            item_val_next = in_ext[VALUE_WIDTH-1:0];
            rd_link_next  = link_chain[CAPACITY];
        end

        if (load)
        begin
            state_next = S_IDLE;
            case (op_reg)
                OP_ADD:
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        status = STATUS_FULL;
                    end
                    else
                    begin
                        free_next   = rd_link_reg;
                        we.value    = 1'b1;
                        val_wr_addr = free_reg;
                        we.link_a   = 1'b1;
                        link_a_addr = free_reg;
                        count_next  = count_reg + ONE_COUNT;
                        fval_next   = item_val_reg;
                        nxt_next    = free_reg;
                        if (count_reg == '0)
                        begin
                            // New node links to itself and takes the cursor
                            link_a_data = free_reg;
                            cur_next    = free_reg;
                            cval_next   = item_val_reg;
                        end
                        else
                        begin
                            link_a_data = nxt_reg;
                            we.link_b   = 1'b1;
                            link_b_addr = cur_reg;
                            link_b_data = free_reg;
                        end
                    end
                end
                OP_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        status = STATUS_EMPTY;
                    end
                    else
                    begin
                        removed     = widen(fval_reg);
                        we.link_a   = 1'b1;
                        link_a_addr = nxt_reg;
                        link_a_data = free_reg;
                        free_next   = nxt_reg;
                        count_next  = count_reg - ONE_COUNT;
                        if (count_reg == ONE_COUNT)
                        begin
                            cur_next = '0;
                            nxt_next = '0;
                        end
                        else
                        begin
                            // Unlink the front node
                            we.link_b   = 1'b1;
                            link_b_addr = cur_reg;
                            link_b_data = rd_link_reg;
                            nxt_next    = rd_link_reg;
                            fval_next   = val_rd;
                        end
                    end
                end
                OP_ADVANCE:
                begin
                    if (count_reg == '0)
                    begin
                        status = STATUS_EMPTY;
                    end
                    else
                    begin
                        cur_next  = nxt_reg;
                        cval_next = fval_reg;
                        nxt_next  = rd_link_reg;
                        fval_next = val_rd;
                    end
                end
                default:
                begin
                    status = STATUS_OK;
                end
            endcase

            res_valid_next              = 1'b1;
            res_item_next.status        = status;
            res_item_next.count         = COUNT_W'(count_next);
            res_item_next.removed_value = removed;
            res_item_next.cursor_value  = (count_next == '0) ? '0 : widen(cval_next);
            res_item_next.front_value   = (count_next == '0) ? '0 : widen(fval_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            nxt_reg       <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            nxt_reg       <= nxt_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        item_val_reg <= item_val_next;
        rd_link_reg  <= rd_link_next;
        cval_reg     <= cval_next;
        fval_reg     <= fval_next;
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `CLWC_ASSERT(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT, "element count above capacity")
    `CLWC_ASSERT(a_empty_cursor, clk, rst_n, (count_reg != '0) || (cur_reg == '0), "empty list with cursor off node zero")
    `CLWC_ASSERT_NEXT(a_full_status, clk, rst_n, load, (res_item_reg.status != STATUS_FULL) || (count_reg == FULL_COUNT), "pool full reported below capacity")

endmodule

[test/tb_circular_list_with_cursor.sv]
// ----------------------------------------------------------------------------
// tb_circular_list_with_cursor
// Self-checking bench for the circular list with a cursor. A tracker class
// keeps its own node pool, free list and cursor, predicts the result beat of
// every accepted operation and compares each result beat field by field.
// Stimulus runs a short directed sequence (empty and full errors, the only
// element removed, the unused operation code, extreme values), then random
// operations in grow, shrink and mixed moods. The sender works in bursts and
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_circular_list_with_cursor;
    import clwc_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int RANDOM_OPS       = 1400;
    localparam int IDLE_LIMIT       = 2000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int TAIL_CYCLES      = 10;

    // The fourth operation code has no name in the package; the block ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] VAL_ZERO  = 32'sh00000000;
    localparam logic signed [DATA_W-1:0] VAL_ONES  = 32'shFFFFFFFF;
    localparam logic signed [DATA_W-1:0] VAL_EVEN  = 32'sh55555555;
    localparam logic signed [DATA_W-1:0] VAL_ODD   = 32'shAAAAAAAA;

    typedef enum int {MOOD_GROW, MOOD_SHRINK, MOOD_MIXED} mood_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

    class list_tracker;
        logic signed [DATA_W-1:0] node_val [CAPACITY];
        logic [3:0]               node_next [CAPACITY];
        logic [3:0]               cursor;
        logic [3:0]               free_top;
        int unsigned              size_now;
        res_item_t                pending_results [$];
        int unsigned              mismatches;
        int unsigned              results_seen;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                node_val[i]  = '0;
                node_next[i] = 4'((i + 1) % CAPACITY);
            end
            cursor       = '0;
            free_top     = '0;
            size_now     = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Update the list for one accepted operation and queue its result.
        function void apply_op(op_item_t beat);
            res_item_t  want;
            logic [3:0] slot;
            want        = '0;
            want.status = STATUS_OK;
            case (beat.operation)
                OP_ADD:
                begin
                    if (size_now >= CAPACITY)
                        want.status = STATUS_FULL;
                    else
                    begin
                        slot           = free_top;
                        free_top       = node_next[slot];
                        node_val[slot] = beat.value;
                        if (size_now == 0)
                        begin
                            node_next[slot] = slot;
                            cursor          = slot;
                        end
                        else
                        begin
                            node_next[slot]   = node_next[cursor];
                            node_next[cursor] = slot;
                        end
                        size_now++;
                    end
                end
                OP_REMOVE:
                begin
                    if (size_now == 0)
                        want.status = STATUS_EMPTY;
                    else
                    begin
                        slot               = node_next[cursor];
                        want.removed_value = node_val[slot];
                        // last element out: list empties and cursor returns home
                        if (size_now == 1)
                            cursor = '0;
                        else
                            node_next[cursor] = node_next[slot];
                        node_next[slot] = free_top;
                        free_top        = slot;
                        size_now--;
                    end
                end
                OP_ADVANCE:
                begin
                    if (size_now == 0)
                        want.status = STATUS_EMPTY;
                    else
                        cursor = node_next[cursor];
                end
                default:
                    ;
            endcase
            want.count = COUNT_W'(size_now);
            if (size_now != 0)
            begin
                want.cursor_value = node_val[cursor];
                want.front_value  = node_val[node_next[cursor]];
            end
            pending_results.push_back(want);
        endfunction

        task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            mismatches++;
            $display("result %0d: %s got %h want %h", results_seen, what, got, want);
        endtask

        task compare_result(res_item_t got);
            res_item_t want;
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("beat with no operation pending", DATA_W'(got.count), '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
                if (got.count !== want.count)
                    report_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
                if (got.removed_value !== want.removed_value)
                    report_mismatch("removed_value", got.removed_value, want.removed_value);
                if (got.cursor_value !== want.cursor_value)
                    report_mismatch("cursor_value", got.cursor_value, want.cursor_value);
                if (got.front_value !== want.front_value)
                    report_mismatch("front_value", got.front_value, want.front_value);
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      op_valid;
    logic      op_stall;
    op_item_t  op_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    int          hold_requests;
    int          idle_cycles;
    list_tracker tracker = new();

    circular_list_with_cursor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_item   (op_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch both channels at every edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (op_valid && !op_stall)
                tracker.apply_op(op_item);
            if (res_valid && !res_stall)
                tracker.compare_result(res_item);
        end
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((op_valid && !op_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL circular_list_with_cursor");
        $finish;
    end

    // Receiver: stall pattern switches between random modes, with long holds on request.
    initial
    begin
        stall_mode_t stall_mode;
        int          mode_left;
        int          holds_done;
        logic        hold;
        res_stall  = 1'b0;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                res_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                case (stall_mode)
                    STALL_LIGHT: hold = ($urandom_range(0, 3) == 0);
                    STALL_HALF:  hold = ($urandom_range(0, 1) == 0);
                    STALL_HEAVY: hold = ($urandom_range(0, 4) != 0);
                    default:     hold = 1'b0;
                endcase
                res_stall <= hold;
            end
        end
    end

    task send_op(input logic [OP_W-1:0] code, input logic signed [DATA_W-1:0] val);
        op_item_t beat;
        beat.operation = code;
        beat.value     = val;
        op_valid <= 1'b1;
        op_item  <= beat;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
    endtask

    // Stop offering beats and wait for every pending result.
    task drain_results();
        op_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [OP_W-1:0]          code;
        logic signed [DATA_W-1:0] val;
        mood_t                    mood;
        int                       mood_left;
        int                       counted;
        int                       burst_left;
        int                       gap;
        int                       roll;
        int                       next_hold_at;
        int                       next_drain_at;

        rst_n         = 1'b0;
        op_valid      = 1'b0;
        op_item       = '0;
        hold_requests = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: errors on empty, the only element, unused code, full pool.
        send_op(OP_REMOVE, VAL_ZERO);
        send_op(OP_ADVANCE, VAL_ZERO);
        send_op(OP_UNUSED, VAL_ONES);
        send_op(OP_ADD, VAL_MAX);
        send_op(OP_ADVANCE, VAL_ZERO);
        send_op(OP_REMOVE, VAL_ZERO);
        send_op(OP_ADD, VAL_MIN);
        send_op(OP_ADD, VAL_ZERO);
        send_op(OP_UNUSED, VAL_ZERO);
        for (int k = 0; k < CAPACITY - 2; k++)
            send_op(OP_ADD, k[0] ? VAL_ODD : VAL_EVEN);
        send_op(OP_ADD, $urandom);
        send_op(OP_REMOVE, VAL_ZERO);
        send_op(OP_ADVANCE, VAL_ZERO);
        drain_results();

        counted       = 0;
        mood          = MOOD_MIXED;
        mood_left     = 0;
        burst_left    = $urandom_range(1, 16);
        next_hold_at  = 50;
        next_drain_at = 300;
        while (counted < RANDOM_OPS)
        begin
            if (counted >= next_drain_at)
            begin
                drain_results();
                next_drain_at += 700;
            end
            if (counted >= next_hold_at)
            begin
                // receiver holds off while a long burst keeps coming
                hold_requests++;
                burst_left    = 14;
                next_hold_at += 650;
            end
            if (mood_left == 0)
            begin
                mood      = mood_t'($urandom_range(0, 2));
                mood_left = $urandom_range(20, 60);
            end
            mood_left--;

            roll = $urandom_range(0, 99);
            if (roll < 3)
                code = OP_UNUSED;
            else
            begin
                case (mood)
                    MOOD_GROW:
                        code = (roll < 63) ? OP_ADD : (roll < 80) ? OP_REMOVE : OP_ADVANCE;
                    MOOD_SHRINK:
                        code = (roll < 23) ? OP_ADD : (roll < 78) ? OP_REMOVE : OP_ADVANCE;
                    default:
                        code = (roll < 40) ? OP_ADD : (roll < 70) ? OP_REMOVE : OP_ADVANCE;
                endcase
            end
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       val = VAL_MAX;
                    1:       val = VAL_MIN;
                    2:       val = VAL_ZERO;
                    default: val = VAL_ONES;
                endcase
            end
            else
                val = $urandom;

            send_op(code, val);
            if (code != OP_UNUSED)
                counted++;

            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    op_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("PASS circular_list_with_cursor");
        else
            $display("FAIL circular_list_with_cursor");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/clwc_pkg.sv
src/clwc_cell.sv
src/circular_list_with_cursor.sv
test/tb_circular_list_with_cursor.sv
